FILE: rtl/core/uxm_pkg.sv
// shared constants, codes and types for the uxrom mapper
package uxm_pkg;

  localparam int MAX_PRG_BANKS   = 16;
  localparam int BANK_BYTES      = 16384;
  localparam int CHR_BYTES       = 8192;
  localparam int NAMETABLE_BYTES = 1024;

  localparam int PRG_TOTAL   = MAX_PRG_BANKS * BANK_BYTES;
  localparam int PRG_BANK_W  = $clog2(MAX_PRG_BANKS);
  localparam int BANK_OFF_W  = $clog2(BANK_BYTES);
  localparam int PRG_ADDR_W  = PRG_BANK_W + BANK_OFF_W;
  localparam int CHR_ADDR_W  = $clog2(CHR_BYTES);
  localparam int NT_OFF_W    = $clog2(NAMETABLE_BYTES);
  localparam int NT_ADDR_W   = NT_OFF_W + 1;
  localparam int NT_DEPTH    = 2 * NAMETABLE_BYTES;

  localparam int MODE_W    = 3;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int OFFSET_W  = 18;
  localparam int BANK_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  // item modes
  localparam logic [MODE_W-1:0] MODE_CPU_RD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CPU_WR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PPU_RD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PPU_WR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PRG_LD  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRRORING      = 1'd1;

  localparam logic [COUNT_W-1:0] PRG_BANK_COUNT_RST = 5'd16;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_PRG,
    SRC_CHR,
    SRC_NT
  } src_t;

  typedef struct packed {
    logic                  prg_we;
    logic [PRG_ADDR_W-1:0] prg_addr;
    logic                  chr_we;
    logic [CHR_ADDR_W-1:0] chr_addr;
    logic                  nt_we;
    logic [NT_ADDR_W-1:0]  nt_addr;
    src_t                  src;
    logic                  err;
  } req_t;

endpackage

FILE: rtl/core/uxm_ram.sv
// generic single-port synchronous ram with registered read
module uxm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/uxm_ctrl.sv
// item decode, bank select and configuration registers of the uxrom mapper
module uxm_ctrl
  import uxm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [MODE_W-1:0]     mode,
  input  logic [ADDR_W-1:0]     bus_address,
  input  logic [DATA_W-1:0]     write_data,
  input  logic [OFFSET_W-1:0]   rom_offset,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output req_t                  req
);

  logic [COUNT_W-1:0] prg_bank_count_r, prg_bank_count_nxt;
  logic               mirroring_r, mirroring_nxt;
  logic [BANK_W-1:0]  bank_select_r, bank_select_nxt;

  logic [COUNT_W-1:0] count_sat;
  logic [COUNT_W-1:0] bank_eff;
  logic               bank_bad;
  logic               nt_table;
  logic               load_ok;

  always_comb begin
    prg_bank_count_nxt = prg_bank_count_r;
    mirroring_nxt      = mirroring_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_BANK_COUNT: prg_bank_count_nxt = cfg_data;
        CFG_MIRRORING:      mirroring_nxt      = cfg_data[0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    count_sat = (prg_bank_count_r > COUNT_W'(MAX_PRG_BANKS)) ?
                COUNT_W'(MAX_PRG_BANKS) : prg_bank_count_r;
    // upper window takes the last bank; a zero count wraps to an out-of-range bank
    bank_eff  = bus_address[ADDR_W-2] ? (prg_bank_count_r - COUNT_W'(1))
                                      : {1'b0, bank_select_r};
    bank_bad  = (bank_eff >= count_sat);
    nt_table  = mirroring_r ? bus_address[NT_OFF_W] : bus_address[NT_OFF_W+1];
    load_ok   = (32'(rom_offset) < 32'(PRG_TOTAL));
  end

  always_comb begin
    bank_select_nxt = bank_select_r;
    req.prg_we   = 1'b0;
    req.prg_addr = {bank_eff[PRG_BANK_W-1:0], bus_address[BANK_OFF_W-1:0]};
    req.chr_we   = 1'b0;
    req.chr_addr = bus_address[CHR_ADDR_W-1:0];
    req.nt_we    = 1'b0;
    req.nt_addr  = {nt_table, bus_address[NT_OFF_W-1:0]};
    req.src      = SRC_NONE;
    req.err      = 1'b0;
    if (accept) begin
      case (mode)
        MODE_CPU_RD: begin
          if (!bus_address[ADDR_W-1] || bank_bad) begin
            req.err = 1'b1;
          end else begin
            req.src = SRC_PRG;
          end
        end
        MODE_CPU_WR: begin
          if (bus_address[ADDR_W-1]) begin
            bank_select_nxt = write_data[BANK_W-1:0];
          end
        end
        MODE_PPU_RD: begin
          req.src = (bus_address[ADDR_W-1:CHR_ADDR_W] == '0) ? SRC_CHR : SRC_NT;
        end
        MODE_PPU_WR: begin
          if (bus_address[ADDR_W-1:CHR_ADDR_W] == '0) begin
            req.chr_we = 1'b1;
          end else begin
            req.nt_we = 1'b1;
          end
        end
        MODE_PRG_LD: begin
          req.prg_addr = rom_offset[PRG_ADDR_W-1:0];
          if (load_ok) begin
            req.prg_we = 1'b1;
          end else begin
            req.err = 1'b1;
          end
        end
        default: req.err = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_count_r <= PRG_BANK_COUNT_RST;
      mirroring_r      <= 1'b0;
      bank_select_r    <= '0;
    end else begin
      prg_bank_count_r <= prg_bank_count_nxt;
      mirroring_r      <= mirroring_nxt;
      bank_select_r    <= bank_select_nxt;
    end
  end

endmodule

FILE: rtl/core/prg_bank_switch_and_nametable_mirror.sv
// uxrom mapper top level: prg rom, chr ram and nametable ram behind one item port
// the result strobe comes in the cycle after the item is accepted
// throughput: one item per cycle while busy is low; each item is one access to one ram port
// reset: bank 0 selected, 16 banks configured, horizontal mirroring
// after reset busy stays high while all 2048 nametable ram entries are cleared
// results cannot be stalled by the receiver
module prg_bank_switch_and_nametable_mirror
  import uxm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [ADDR_W-1:0]     in_bus_address,
  input  logic [DATA_W-1:0]     in_write_data,
  input  logic [OFFSET_W-1:0]   in_rom_offset,
  output logic                  out_valid,
  output logic [DATA_W-1:0]     out_read_data,
  output logic                  out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  req_t                 req;
  logic                 accept;
  logic                 clr_active_r, clr_active_nxt;
  logic [NT_ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                 out_valid_r;
  src_t                 src_r;
  logic                 err_r;

  logic [DATA_W-1:0]    prg_q, chr_q, nt_q;
  logic                 nt_we;
  logic [NT_ADDR_W-1:0] nt_addr;
  logic [DATA_W-1:0]    nt_wdata;

  assign busy   = clr_active_r;
  assign accept = start && !clr_active_r;

  uxm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .mode        (in_mode),
    .bus_address (in_bus_address),
    .write_data  (in_write_data),
    .rom_offset  (in_rom_offset),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req         (req)
  );

  uxm_ram #(.WIDTH(DATA_W), .DEPTH(PRG_TOTAL)) u_prg_ram (
    .clk   (clk),
    .we    (req.prg_we),
    .addr  (req.prg_addr),
    .wdata (in_write_data),
    .rdata (prg_q)
  );

  uxm_ram #(.WIDTH(DATA_W), .DEPTH(CHR_BYTES)) u_chr_ram (
    .clk   (clk),
    .we    (req.chr_we),
    .addr  (req.chr_addr),
    .wdata (in_write_data),
    .rdata (chr_q)
  );

  // the clearing sweep owns the nametable port until it is done
  assign nt_we    = clr_active_r || req.nt_we;
  assign nt_addr  = clr_active_r ? clr_cnt_r : req.nt_addr;
  assign nt_wdata = clr_active_r ? '0 : in_write_data;

  uxm_ram #(.WIDTH(DATA_W), .DEPTH(NT_DEPTH)) u_nt_ram (
    .clk   (clk),
    .we    (nt_we),
    .addr  (nt_addr),
    .wdata (nt_wdata),
    .rdata (nt_q)
  );

  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    clr_active_nxt = clr_active_r;
    if (clr_active_r) begin
      clr_cnt_nxt = clr_cnt_r + NT_ADDR_W'(1);
      if (clr_cnt_r == '1) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= req.src;
    err_r <= req.err;
  end

  always_comb begin
    case (src_r)
      SRC_PRG: out_read_data = prg_q;
      SRC_CHR: out_read_data = chr_q;
      SRC_NT:  out_read_data = nt_q;
      default: out_read_data = '0;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = err_r;

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result strobe without an accepted item");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_read_data == '0))
    else $error("error result carries non-zero data");

  a_clear_runs_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> ($past(clr_cnt_r) == '1))
    else $error("nametable clear ended early");

  a_no_strobe_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> !out_valid)
    else $error("result produced during nametable clear");

endmodule

FILE: tb/prg_bank_switch_and_nametable_mirror_test.sv
// self-checking testbench for the uxrom mapper: directed table, then randomised bus traffic
module prg_bank_switch_and_nametable_mirror_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uxm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int PHASES = 8;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;

  localparam logic [ADDR_W-1:0] PRG_WINDOW   = 16'h8000;
  localparam logic [ADDR_W-1:0] FIXED_WINDOW = 16'hC000;
  localparam logic [ADDR_W-1:0] CHR_TOP      = 16'h1FFF;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
    logic [OFFSET_W-1:0] offset;
    bit                  typed;
    logic [DATA_W-1:0]   rd;
    logic                st;
  } bus_item_t;

  typedef struct {
    logic [DATA_W-1:0] rd;
    logic              st;
  } bus_reply_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [MODE_W-1:0]     in_mode = '0;
  logic [ADDR_W-1:0]     in_bus_address = '0;
  logic [DATA_W-1:0]     in_write_data = '0;
  logic [OFFSET_W-1:0]   in_rom_offset = '0;
  logic                  out_valid;
  logic [DATA_W-1:0]     out_read_data;
  logic                  out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  prg_bank_switch_and_nametable_mirror uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .in_rom_offset  (in_rom_offset),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // mapper state as the block should hold it
  logic [COUNT_W-1:0] bank_count_m = PRG_BANK_COUNT_RST;
  logic               mirror_m = 1'b0;
  logic [BANK_W-1:0]  bank_sel_m = '0;
  logic [DATA_W-1:0]  prg_mem [PRG_TOTAL];
  logic [DATA_W-1:0]  chr_mem [CHR_BYTES];
  logic [DATA_W-1:0]  nt_mem [NT_DEPTH];
  bit                 prg_written [PRG_TOTAL];
  bit                 chr_written [CHR_BYTES];
  int                 prg_loaded [$];
  int                 chr_loaded [$];

  bus_reply_t pending_replies [$];
  int         errors = 0;
  int         cycles = 0;
  bit         idle_on = 1'b1;

  bus_item_t directed_rows [25] = '{
    // nametables read back as zero after the clearing pass
    '{MODE_PPU_RD, 16'h2000, 8'h00, 18'h00000, 1'b1, 8'h00, 1'b0},
    '{MODE_PPU_RD, 16'hFFFF, 8'hFF, 18'h3FFFF, 1'b1, 8'h00, 1'b0},
    '{MODE_CPU_RD, 16'h0000, 8'h00, 18'h00000, 1'b1, 8'h00, 1'b1},
    '{MODE_CPU_RD, 16'h7FFF, 8'hFF, 18'h3FFFF, 1'b1, 8'h00, 1'b1},
    '{MODE_UNUSED_LO, 16'h8000, 8'h00, 18'h00000, 1'b1, 8'h00, 1'b1},
    '{MODE_UNUSED_MID, 16'h0000, 8'h55, 18'h15555, 1'b1, 8'h00, 1'b1},
    '{MODE_UNUSED_HI, 16'hFFFF, 8'hFF, 18'h3FFFF, 1'b1, 8'h00, 1'b1},
    '{MODE_PRG_LD, 16'h0000, 8'hA5, 18'h00000, 1'b1, 8'h00, 1'b0},
    '{MODE_PRG_LD, 16'hFFFF, 8'hFF, 18'h3FFFF, 1'b1, 8'h00, 1'b0},
    '{MODE_PRG_LD, 16'h0000, 8'h5A, 18'h3C000, 1'b1, 8'h00, 1'b0},
    '{MODE_PRG_LD, 16'h0000, 8'h00, 18'h03FFF, 1'b1, 8'h00, 1'b0},
    '{MODE_CPU_RD, 16'h8000, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0},
    '{MODE_CPU_RD, 16'hBFFF, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0},
    '{MODE_CPU_RD, 16'hC000, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0},
    '{MODE_CPU_RD, 16'hFFFF, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0},
    // write below the bank register is ignored
    '{MODE_CPU_WR, 16'h7FFF, 8'h0F, 18'h00000, 1'b1, 8'h00, 1'b0},
    '{MODE_CPU_WR, 16'h8000, 8'hFF, 18'h00000, 1'b1, 8'h00, 1'b0},
    '{MODE_CPU_RD, 16'hBFFF, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0},
    '{MODE_CPU_WR, 16'hFFFF, 8'hF0, 18'h00000, 1'b1, 8'h00, 1'b0},
    '{MODE_PPU_WR, 16'h0000, 8'h3C, 18'h00000, 1'b1, 8'h00, 1'b0},
    '{MODE_PPU_WR, 16'h1FFF, 8'hC3, 18'h00000, 1'b1, 8'h00, 1'b0},
    '{MODE_PPU_RD, 16'h0000, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0},
    // chr write must not have reached the nametable behind the same low bits
    '{MODE_PPU_RD, 16'h2FFF, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0},
    '{MODE_PPU_WR, 16'h2C00, 8'h77, 18'h00000, 1'b1, 8'h00, 1'b0},
    '{MODE_PPU_RD, 16'h3C00, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0}
  };

  int phase_count [PHASES] = '{16, 1, 0, 31, 8, 17, 2, 16};
  bit phase_mirror [PHASES] = '{1, 0, 1, 0, 1, 1, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // prg position a cpu read reaches, or -1 when it errors without a store access
  function automatic int cpu_read_pos(logic [ADDR_W-1:0] addr);
    int bank;
    int loaded;
    if (addr < PRG_WINDOW) return -1;
    if (addr < FIXED_WINDOW) bank = bank_sel_m;
    else if (bank_count_m == 0) bank = MAX_PRG_BANKS;
    else bank = int'(bank_count_m) - 1;
    loaded = (bank_count_m > MAX_PRG_BANKS) ? MAX_PRG_BANKS : int'(bank_count_m);
    if (bank >= loaded) return -1;
    return bank * BANK_BYTES + int'(addr[BANK_OFF_W-1:0]);
  endfunction

  function automatic int nt_slot(logic [ADDR_W-1:0] addr);
    logic table_sel;
    table_sel = mirror_m ? addr[10] : addr[11];
    return int'({table_sel, addr[NT_OFF_W-1:0]});
  endfunction

  function automatic bus_reply_t map_access(bus_item_t it);
    bus_reply_t r;
    int pos;
    r.rd = '0;
    r.st = 1'b0;
    case (it.mode)
      MODE_CPU_RD: begin
        pos = cpu_read_pos(it.addr);
        if (pos < 0) r.st = 1'b1;
        else r.rd = prg_mem[pos];
      end
      MODE_CPU_WR: begin
        if (it.addr >= PRG_WINDOW) bank_sel_m = it.wdata[BANK_W-1:0];
      end
      MODE_PPU_RD: begin
        if (it.addr <= CHR_TOP) r.rd = chr_mem[it.addr[CHR_ADDR_W-1:0]];
        else r.rd = nt_mem[nt_slot(it.addr)];
      end
      MODE_PPU_WR: begin
        if (it.addr <= CHR_TOP) begin
          chr_mem[it.addr[CHR_ADDR_W-1:0]] = it.wdata;
          if (!chr_written[it.addr[CHR_ADDR_W-1:0]])
            chr_loaded.push_back(int'(it.addr[CHR_ADDR_W-1:0]));
          chr_written[it.addr[CHR_ADDR_W-1:0]] = 1'b1;
        end else begin
          nt_mem[nt_slot(it.addr)] = it.wdata;
        end
      end
      MODE_PRG_LD: begin
        if (it.offset < PRG_TOTAL) begin
          prg_mem[it.offset] = it.wdata;
          if (!prg_written[it.offset]) prg_loaded.push_back(int'(it.offset));
          prg_written[it.offset] = 1'b1;
        end else begin
          r.st = 1'b1;
        end
      end
      default: r.st = 1'b1;
    endcase
    return r;
  endfunction

  task automatic send_item(bus_item_t it);
    bus_reply_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= it.mode;
    in_bus_address <= it.addr;
    in_write_data <= it.wdata;
    in_rom_offset <= it.offset;
    do @(posedge clk); while (busy !== 1'b0);
    r = map_access(it);
    if (it.typed) begin
      r.rd = it.rd;
      r.st = it.st;
    end
    pending_replies.push_back(r);
  endtask

  // fills a never-written prg or chr entry before a read of it
  task automatic send_filled(bus_item_t it);
    bus_item_t fill;
    int pos;
    fill = it;
    fill.wdata = DATA_W'($urandom);
    if (it.mode == MODE_CPU_RD) begin
      pos = cpu_read_pos(it.addr);
      if (pos >= 0 && !prg_written[pos]) begin
        fill.mode = MODE_PRG_LD;
        fill.offset = OFFSET_W'(pos);
        send_item(fill);
      end
    end else if (it.mode == MODE_PPU_RD && it.addr <= CHR_TOP) begin
      if (!chr_written[it.addr[CHR_ADDR_W-1:0]]) begin
        fill.mode = MODE_PPU_WR;
        send_item(fill);
      end
    end
    send_item(it);
  endtask

  function automatic logic [MODE_W-1:0] MODE_MODE_PICK();
    case ($urandom_range(0, 2))
      0: return MODE_UNUSED_LO;
      1: return MODE_UNUSED_MID;
      default: return MODE_UNUSED_HI;
    endcase
  endfunction

  task automatic issue_random_item();
    bus_item_t it;
    bus_item_t sw;
    int kind;
    int o;
    kind = $urandom_range(0, 99);
    it.mode = MODE_CPU_RD;
    it.addr = ADDR_W'($urandom);
    it.wdata = DATA_W'($urandom);
    it.offset = OFFSET_W'($urandom);
    it.typed = 1'b0;
    it.rd = '0;
    it.st = 1'b0;
    if (kind < 15) begin
      it.addr[15] = 1'b1;
    end else if (kind < 30 && prg_loaded.size() > 0) begin
      // bank switch, then read back a loaded byte through the switchable window
      o = prg_loaded[$urandom_range(0, prg_loaded.size() - 1)];
      sw = it;
      sw.mode = MODE_CPU_WR;
      sw.addr[15] = 1'b1;
      sw.wdata[BANK_W-1:0] = BANK_W'(o >> BANK_OFF_W);
      send_item(sw);
      it.addr = PRG_WINDOW | ADDR_W'(o % BANK_BYTES);
    end else if (kind < 40) begin
      it.mode = MODE_CPU_WR;
      if ($urandom_range(0, 4) != 0) it.addr[15] = 1'b1;
    end else if (kind < 52) begin
      it.mode = MODE_PPU_RD;
    end else if (kind < 60 && chr_loaded.size() > 0) begin
      it.mode = MODE_PPU_RD;
      it.addr = ADDR_W'(chr_loaded[$urandom_range(0, chr_loaded.size() - 1)]);
    end else if (kind < 75) begin
      it.mode = MODE_PPU_WR;
      if ($urandom_range(0, 1) == 0) it.addr[15:13] = 3'b000;
    end else if (kind < 90) begin
      it.mode = MODE_PRG_LD;
    end else if (kind < 95) begin
      it.addr[15] = 1'b0;
    end else begin
      it.mode = MODE_MODE_PICK();
    end
    send_filled(it);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_PRG_BANK_COUNT) bank_count_m = value[COUNT_W-1:0];
    else if (idx == CFG_MIRRORING) mirror_m = value[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : reply_check
    bus_reply_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: read_data %h status %b", out_read_data, out_status);
      end else begin
        want = pending_replies.pop_front();
        if (out_read_data !== want.rd || out_status !== want.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: read_data exp %h got %h, status exp %b got %b",
                     want.rd, out_read_data, want.st, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    foreach (nt_mem[i]) nt_mem[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // nametable clearing pass keeps busy high after reset
    do @(posedge clk); while (busy !== 1'b0);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_register(CFG_PRG_BANK_COUNT, CFG_DATA_W'(phase_count[p]));
      set_register(CFG_MIRRORING, CFG_DATA_W'(phase_mirror[p]));
      idle_on = (p != PHASES - 1);
      repeat (ITEMS_PER_PHASE) issue_random_item();
      drain();
    end

    if (errors == 0 && pending_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/uxm_pkg.sv
rtl/core/uxm_ram.sv
rtl/core/uxm_ctrl.sv
rtl/core/prg_bank_switch_and_nametable_mirror.sv
tb/prg_bank_switch_and_nametable_mirror_test.sv
